// File: design/fqse_pkg.sv
// ----------------------------------------------------------------------------
// fqse_pkg: form query string encoder shared definitions
// Mode codes, beat payload types, the front-to-back queue entry and defaults.
// ----------------------------------------------------------------------------
package fqse_pkg;

   localparam int LENGTH_BITS_DEFAULT = 16;
   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam logic [15:0] OUT_SIZE_RESET = 16'd4096;

   localparam logic [2:0] MODE_START_QUERY = 3'd0;
   localparam logic [2:0] MODE_START_PAIR  = 3'd1;
   localparam logic [2:0] MODE_NAME_BYTE   = 3'd2;
   localparam logic [2:0] MODE_SEPARATOR   = 3'd3;
   localparam logic [2:0] MODE_VALUE_BYTE  = 3'd4;

   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_AMP     = 8'h26;
   localparam logic [7:0] CHAR_EQUALS  = 8'h3D;
   localparam logic [7:0] CHAR_TILDE   = 8'h7E;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_DASH    = 8'h2D;
   localparam logic [7:0] CHAR_UNDER   = 8'h5F;
   localparam logic [7:0] CHAR_DOT     = 8'h2E;

   typedef struct packed {
      logic [2:0] mode;
      logic [7:0] in_byte;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic [15:0] out_length;
      logic        last;
   } rsp_type;

   // One queued encoding: one byte, or three bytes for a percent escape.
   typedef struct packed {
      logic        three;
      logic [7:0]  byte0;
      logic [7:0]  byte1;
      logic [7:0]  byte2;
      logic [15:0] base_length;
   } entry_type;

endpackage

// File: design/fqse_front.sv
// ----------------------------------------------------------------------------
// fqse_front: item classifier and length tracker
// Accepts one item per cycle while the queue is not full, checks capacity, updates length and the field
// halt flag, and queues the encoded bytes of each item that emits anything.
// ----------------------------------------------------------------------------
module fqse_front #(
   parameter int LENGTH_BITS = fqse_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  fqse_pkg::req_type   req_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [15:0]         csr_data,
   output logic                q_push,
   output fqse_pkg::entry_type q_entry,
   input  logic                q_full
);

   localparam int CW = ((LENGTH_BITS > 16) ? LENGTH_BITS : 16) + 2;

   logic [LENGTH_BITS-1:0] length_ff, length_in;
   logic                   halted_ff, halted_in;
   logic [15:0]            out_size_ff;

   logic [CW-1:0] len_w, size_w, lim_w, cap_w;
   logic          fits1, fits3, accept, plain;

   function automatic logic [7:0] hex_digit(input logic [3:0] nib);
      logic [7:0] d;
      if (nib < 4'd10) begin
         d = 8'h30 + {4'd0, nib};
      end else begin
         d = 8'h37 + {4'd0, nib};
      end
      return d;
   endfunction

   function automatic logic passes(input logic [7:0] c);
      logic p;
      p = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
          (c >= 8'h30 && c <= 8'h39) || c == fqse_pkg::CHAR_DASH ||
          c == fqse_pkg::CHAR_UNDER || c == fqse_pkg::CHAR_DOT ||
          c == fqse_pkg::CHAR_TILDE;
      return p;
   endfunction

   assign accept    = req_push && !q_full;
   assign req_full  = q_full;
   assign csr_ready = 1'b1;

   assign len_w  = CW'(length_ff);
   assign size_w = CW'(out_size_ff);
   assign lim_w  = CW'(1) << LENGTH_BITS;
   assign cap_w  = (size_w < lim_w) ? size_w : lim_w;
   assign fits1  = (len_w + CW'(1)) < cap_w;
   assign fits3  = (len_w + CW'(3)) < cap_w;
   assign plain  = passes(req_data.in_byte) || req_data.in_byte == fqse_pkg::CHAR_SPACE;

   always_comb begin
      length_in           = length_ff;
      halted_in           = halted_ff;
      q_push              = 1'b0;
      q_entry.three       = 1'b0;
      q_entry.byte0       = req_data.in_byte;
      q_entry.byte1       = hex_digit(req_data.in_byte[7:4]);
      q_entry.byte2       = hex_digit(req_data.in_byte[3:0]);
      q_entry.base_length = len_w[15:0];
      if (accept) begin
         unique case (req_data.mode) inside
            fqse_pkg::MODE_START_QUERY: begin
               length_in = '0;
               halted_in = 1'b0;
            end
            fqse_pkg::MODE_START_PAIR: begin
               halted_in     = 1'b0;
               q_entry.byte0 = fqse_pkg::CHAR_AMP;
               if (length_ff != '0 && fits1) begin
                  q_push    = 1'b1;
                  length_in = length_ff + 1'b1;
               end
            end
            fqse_pkg::MODE_SEPARATOR: begin
               halted_in     = 1'b0;
               q_entry.byte0 = fqse_pkg::CHAR_EQUALS;
               if (fits1) begin
                  q_push    = 1'b1;
                  length_in = length_ff + 1'b1;
               end
            end
            fqse_pkg::MODE_NAME_BYTE, fqse_pkg::MODE_VALUE_BYTE: begin
               if (!halted_ff) begin
                  if (plain) begin
                     if (req_data.in_byte == fqse_pkg::CHAR_SPACE) begin
                        q_entry.byte0 = fqse_pkg::CHAR_PLUS;
                     end
                     if (fits1) begin
                        q_push    = 1'b1;
                        length_in = length_ff + 1'b1;
                     end else begin
                        halted_in = 1'b1;
                     end
                  end else begin
                     q_entry.three = 1'b1;
                     q_entry.byte0 = fqse_pkg::CHAR_PERCENT;
                     if (fits3) begin
                        q_push    = 1'b1;
                        length_in = length_ff + LENGTH_BITS'(3);
                     end else begin
                        halted_in = 1'b1;
                     end
                  end
               end
            end
            default: begin
               // undefined modes: drop
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff   <= '0;
         halted_ff   <= 1'b0;
         out_size_ff <= fqse_pkg::OUT_SIZE_RESET;
      end else begin
         length_ff <= length_in;
         halted_ff <= halted_in;
         if (csr_valid && csr_ready) begin
            out_size_ff <= csr_data;
         end
      end
   end

endmodule

// File: design/fqse_fifo.sv
// ----------------------------------------------------------------------------
// fqse_fifo: short entry queue between front and back
// Register-based FIFO; the head entry is visible while not empty.
// ----------------------------------------------------------------------------
module fqse_fifo #(
   parameter int DEPTH = fqse_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  fqse_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output fqse_pkg::entry_type head,
   output logic                empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   fqse_pkg::entry_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign full    = count_ff == NW'(DEPTH);
   assign empty   = count_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: design/fqse_back.sv
// ----------------------------------------------------------------------------
// fqse_back: beat expander and result register
// Walks the head entry into the result register one beat per cycle while it
// is free or popped, computing the running length and marking the final beat.
// ----------------------------------------------------------------------------
module fqse_back (
   input  logic                clock,
   input  logic                reset,
   input  fqse_pkg::entry_type src,
   input  logic                src_empty,
   output logic                src_pop,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output fqse_pkg::rsp_type   rsp_data
);

   logic [1:0]        idx_ff, idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   fqse_pkg::rsp_type rsp_data_ff;
   fqse_pkg::rsp_type beat;
   logic              load, src_last;

   assign src_last = !src.three || idx_ff == 2'd2;
   assign load     = !src_empty && (!rsp_valid_ff || rsp_pop);
   assign src_pop  = load && src_last;

   always_comb begin
      case (idx_ff)
         2'd0:    beat.out_byte = src.byte0;
         2'd1:    beat.out_byte = src.byte1;
         default: beat.out_byte = src.byte2;
      endcase
      beat.out_length = src.base_length + 16'(idx_ff) + 16'd1;
      beat.last       = src_last;
   end

   always_comb begin
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
         // advance within the entry, restart on its final beat
         idx_in = src_last ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= beat;
      end
   end

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_mid_entry_held: assert property (@(posedge clock) disable iff (reset)
      idx_ff != 2'd0 |-> !src_empty)
      else $error("back: entry left the queue before its last beat");

   a_triple_only: assert property (@(posedge clock) disable iff (reset)
      idx_ff != 2'd0 |-> src.three)
      else $error("back: beat index past a single-byte entry");

   a_advance: assert property (@(posedge clock) disable iff (reset)
      load && !src_last |=> idx_ff == $past(idx_ff) + 2'd1)
      else $error("back: beat index did not advance");
`endif

endmodule

// File: design/form_query_string_encoder_top.sv
// A taken item's entry is queued, then each of its beats is registered to the ports.
// Throughput: one input item per cycle while the entry queue has room; results
// leave at one beat per cycle while popped, so a percent-escaped byte takes three
// result beats and the output channel sets the sustained rate.
// Reset: clears the query length, field halt flag and queue, and sets out_size to 4096.
// ----------------------------------------------------------------------------
// form_query_string_encoder_top: form query string encoder
// Front classifies items and tracks length, a short queue holds encodings,
// and the back streams encoded bytes one per beat.
// ----------------------------------------------------------------------------
module form_query_string_encoder_top #(
   parameter int LENGTH_BITS = fqse_pkg::LENGTH_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = fqse_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  fqse_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output fqse_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [15:0]       csr_data
);

   logic                q_push, q_full, q_pop, q_empty;
   fqse_pkg::entry_type q_entry, q_head;

   fqse_front #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .q_push    (q_push),
      .q_entry   (q_entry),
      .q_full    (q_full)
   );

   fqse_fifo #(
      .DEPTH(QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head       (q_head),
      .empty      (q_empty)
   );

   fqse_back u_back (
      .clock     (clock),
      .reset     (reset),
      .src       (q_head),
      .src_empty (q_empty),
      .src_pop   (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: form query string encoder testbench
// Streams marker and byte items into the encoder under bursty input and a
// stalling output. Each encoded output byte, with its running length and last
// flag, is checked against a local model of the query encoding. The buffer
// size is changed between phases, from zero up to the full 16-bit range.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int TIMEOUT_CYCLES = 5000;
   localparam int SETTLE_CYCLES  = 8;

   logic              clock;
   logic              reset     = 1'b1;
   logic              req_push  = 1'b0;
   logic              req_full;
   fqse_pkg::req_type req_data  = '0;
   logic              rsp_empty;
   logic              rsp_pop   = 1'b0;
   fqse_pkg::rsp_type rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [15:0]       csr_data  = '0;

   // Local copy of the encoder state and its one register
   logic [15:0] size_reg      = fqse_pkg::OUT_SIZE_RESET;
   logic [15:0] query_len     = '0;
   logic        field_dropped = 1'b0;

   fqse_pkg::req_type pending_items[$];
   fqse_pkg::rsp_type expected_bytes[$];

   logic req_beat     = 1'b0;
   int   burst_left   = 0;
   int   gap_left     = 0;
   int   pop_window   = 0;
   int   pop_style    = 0;
   int   quiet_cycles = 0;
   int   failures     = 0;
   int   items_taken  = 0;
   int   beats_checked = 0;
   int   size_writes  = 0;
   int   drops        = 0;

   form_query_string_encoder_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic is_plain_char(input logic [7:0] b);
      return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") ||
             (b >= "0" && b <= "9") || b == fqse_pkg::CHAR_DASH ||
             b == fqse_pkg::CHAR_UNDER || b == fqse_pkg::CHAR_DOT ||
             b == fqse_pkg::CHAR_TILDE;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      return (n < 4'd10) ? 8'h30 + n : 8'h41 + n - 8'd10;
   endfunction

   function automatic void append_expected(input logic [7:0] b);
      fqse_pkg::rsp_type r;
      query_len = query_len + 16'd1;
      r.out_byte = b;
      r.out_length = query_len;
      r.last = 1'b0;
      expected_bytes.push_back(r);
   endfunction

   function automatic void predict_encoding(input fqse_pkg::req_type item);
      int used;
      int cap;
      int before_count;
      fqse_pkg::rsp_type tail;
      used = int'(query_len);
      cap = int'(size_reg);
      before_count = expected_bytes.size();
      case (item.mode) inside
         fqse_pkg::MODE_START_QUERY: begin
            query_len = '0;
            field_dropped = 1'b0;
         end
         fqse_pkg::MODE_START_PAIR: begin
            field_dropped = 1'b0;
            if (used != 0 && used + 1 < cap) append_expected(fqse_pkg::CHAR_AMP);
         end
         fqse_pkg::MODE_SEPARATOR: begin
            field_dropped = 1'b0;
            if (used + 1 < cap) append_expected(fqse_pkg::CHAR_EQUALS);
         end
         fqse_pkg::MODE_NAME_BYTE, fqse_pkg::MODE_VALUE_BYTE: begin
            if (!field_dropped) begin
               if (is_plain_char(item.in_byte) ||
                   item.in_byte == fqse_pkg::CHAR_SPACE) begin
                  if (used + 1 >= cap) begin
                     field_dropped = 1'b1;
                     drops++;
                  end else begin
                     append_expected(item.in_byte == fqse_pkg::CHAR_SPACE ?
                                     fqse_pkg::CHAR_PLUS : item.in_byte);
                  end
               end else if (used + 3 >= cap) begin
                  field_dropped = 1'b1;
                  drops++;
               end else begin
                  append_expected(fqse_pkg::CHAR_PERCENT);
                  append_expected(hex_char(item.in_byte[7:4]));
                  append_expected(hex_char(item.in_byte[3:0]));
               end
            end
         end
         default: ;
      endcase
      // Flag the final byte of this item
      if (expected_bytes.size() > before_count) begin
         tail = expected_bytes.pop_back();
         tail.last = 1'b1;
         expected_bytes.push_back(tail);
      end
   endfunction

   function automatic void report_failure(input string msg);
      failures++;
      if (failures <= 10) $display("ERROR: %s", msg);
   endfunction

   function automatic void queue_item(input logic [2:0] mode, input logic [7:0] value);
      fqse_pkg::req_type item;
      item.mode = mode;
      item.in_byte = value;
      pending_items.push_back(item);
   endfunction

   function automatic logic [7:0] pick_text_byte();
      case ($urandom_range(0, 5))
         0: return 8'($urandom_range(0, 255));
         1: return 8'($urandom_range(8'h61, 8'h7A));
         2: return $urandom_range(0, 1) ? 8'($urandom_range(8'h41, 8'h5A))
                                        : 8'($urandom_range(8'h30, 8'h39));
         3: begin
            case ($urandom_range(0, 4))
               0: return fqse_pkg::CHAR_DASH;
               1: return fqse_pkg::CHAR_UNDER;
               2: return fqse_pkg::CHAR_DOT;
               3: return fqse_pkg::CHAR_TILDE;
               default: return fqse_pkg::CHAR_SPACE;
            endcase
         end
         4: begin
            // Neighbors of the pass-through ranges
            case ($urandom_range(0, 6))
               0: return 8'h2F;
               1: return 8'h3A;
               2: return 8'h40;
               3: return 8'h5B;
               4: return 8'h60;
               5: return 8'h7B;
               default: return 8'h7F;
            endcase
         end
         default: return 8'($urandom_range(8'h80, 8'hFF));
      endcase
   endfunction

   function automatic void queue_short_query();
      queue_item(fqse_pkg::MODE_START_QUERY, 8'h00);
      queue_item(fqse_pkg::MODE_START_PAIR, 8'hFF);
      queue_item(fqse_pkg::MODE_NAME_BYTE, "k");
      queue_item(fqse_pkg::MODE_SEPARATOR, 8'h00);
      queue_item(fqse_pkg::MODE_VALUE_BYTE, fqse_pkg::CHAR_PERCENT);
      queue_item(fqse_pkg::MODE_VALUE_BYTE, "v");
      queue_item(fqse_pkg::MODE_START_PAIR, 8'h00);
      queue_item(fqse_pkg::MODE_NAME_BYTE, "n");
      queue_item(fqse_pkg::MODE_SEPARATOR, 8'hFF);
      queue_item(fqse_pkg::MODE_VALUE_BYTE, fqse_pkg::CHAR_SPACE);
   endfunction

   // Mostly well-formed pairs with random content, some noise and missing separators
   function automatic void queue_random_items(input int count);
      int made;
      int names;
      int values;
      made = 0;
      if ($urandom_range(0, 1)) begin
         queue_item(fqse_pkg::MODE_START_QUERY, 8'($urandom));
         made++;
      end
      while (made < count) begin
         if ($urandom_range(0, 9) == 0) begin
            queue_item(3'($urandom_range(0, 7)), pick_text_byte());
            made++;
         end else begin
            names = $urandom_range(1, 4);
            values = $urandom_range(0, 5);
            queue_item(fqse_pkg::MODE_START_PAIR, 8'($urandom));
            made++;
            repeat (names) begin
               queue_item(fqse_pkg::MODE_NAME_BYTE, pick_text_byte());
               made++;
            end
            if ($urandom_range(0, 7) != 0) begin
               queue_item(fqse_pkg::MODE_SEPARATOR, 8'($urandom));
               made++;
            end
            repeat (values) begin
               queue_item(fqse_pkg::MODE_VALUE_BYTE, pick_text_byte());
               made++;
            end
         end
      end
   endfunction

   task automatic wait_until_drained();
      while (pending_items.size() != 0 || req_push || expected_bytes.size() != 0)
         @(posedge clock);
      // Let items that produce nothing clear the pipeline
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_out_size(input logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Sender: bursts of random length with random gaps in between
   always @(negedge clock) begin
      if (!reset && (!req_push || req_beat)) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_push <= 1'b0;
         end else if (pending_items.size() > 0) begin
            req_push <= 1'b1;
            req_data <= pending_items.pop_front();
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 24);
               gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // Receiver: switch between always ready, periodic and random stalls
   always @(negedge clock) begin
      if (pop_window == 0) begin
         pop_window <= $urandom_range(20, 80);
         pop_style <= $urandom_range(0, 3);
      end else begin
         pop_window <= pop_window - 1;
      end
      case (pop_style)
         0: rsp_pop <= 1'b1;
         1: rsp_pop <= (pop_window % 4 != 0);
         2: rsp_pop <= ($urandom_range(0, 1) == 0);
         default: rsp_pop <= ($urandom_range(0, 3) == 0);
      endcase
   end

   always @(posedge clock) begin : monitor
      fqse_pkg::rsp_type want;
      if (reset) begin
         req_beat <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         req_beat <= req_push && !req_full;
         // Check before predicting so this edge's pops see only older items
         if (!rsp_empty && rsp_pop) begin
            if (expected_bytes.size() == 0) begin
               report_failure($sformatf("unexpected beat: byte %02h length %0d last %0b",
                                        rsp_data.out_byte, rsp_data.out_length,
                                        rsp_data.last));
            end else begin
               want = expected_bytes.pop_front();
               beats_checked++;
               if (rsp_data.out_byte !== want.out_byte ||
                   rsp_data.out_length !== want.out_length ||
                   rsp_data.last !== want.last)
                  report_failure($sformatf(
                     "beat %0d: want byte %02h len %0d last %0b, got %02h len %0d last %0b",
                     beats_checked, want.out_byte, want.out_length, want.last,
                     rsp_data.out_byte, rsp_data.out_length, rsp_data.last));
            end
         end
         if (req_push && !req_full) begin
            predict_encoding(req_data);
            items_taken++;
         end
         if (csr_valid && csr_ready) begin
            size_reg = csr_data;
            size_writes++;
         end
         if ((req_push && !req_full) || (!rsp_empty && rsp_pop) || (csr_valid && csr_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      wait (!reset);
      while (quiet_cycles < TIMEOUT_CYCLES) @(posedge clock);
      $display("ERROR: no progress for %0d cycles, %0d bytes still expected",
               TIMEOUT_CYCLES, expected_bytes.size());
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      logic [15:0] next_size;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: byte ahead of any pair, empty-query pair, every character class
      queue_item(fqse_pkg::MODE_START_QUERY, 8'h00);
      queue_item(fqse_pkg::MODE_VALUE_BYTE, "x");
      queue_item(fqse_pkg::MODE_START_QUERY, 8'hFF);
      queue_item(fqse_pkg::MODE_START_PAIR, 8'h00);
      queue_item(fqse_pkg::MODE_NAME_BYTE, "A");
      queue_item(fqse_pkg::MODE_NAME_BYTE, "Z");
      queue_item(fqse_pkg::MODE_NAME_BYTE, "a");
      queue_item(fqse_pkg::MODE_NAME_BYTE, "z");
      queue_item(fqse_pkg::MODE_NAME_BYTE, "0");
      queue_item(fqse_pkg::MODE_NAME_BYTE, "9");
      queue_item(fqse_pkg::MODE_SEPARATOR, 8'h00);
      queue_item(fqse_pkg::MODE_VALUE_BYTE, fqse_pkg::CHAR_DASH);
      queue_item(fqse_pkg::MODE_VALUE_BYTE, fqse_pkg::CHAR_UNDER);
      queue_item(fqse_pkg::MODE_VALUE_BYTE, fqse_pkg::CHAR_DOT);
      queue_item(fqse_pkg::MODE_VALUE_BYTE, fqse_pkg::CHAR_TILDE);
      queue_item(fqse_pkg::MODE_VALUE_BYTE, fqse_pkg::CHAR_SPACE);
      queue_item(fqse_pkg::MODE_VALUE_BYTE, 8'h00);
      queue_item(fqse_pkg::MODE_VALUE_BYTE, 8'hFF);
      queue_item(fqse_pkg::MODE_VALUE_BYTE, 8'h2F);
      queue_item(fqse_pkg::MODE_VALUE_BYTE, 8'h40);
      queue_item(fqse_pkg::MODE_VALUE_BYTE, 8'h7B);
      queue_item(fqse_pkg::MODE_START_PAIR, 8'h00);
      for (int m = fqse_pkg::MODE_VALUE_BYTE + 1; m < 8; m++) queue_item(3'(m), 8'hA5);
      wait_until_drained();

      // Tiny buffers, zero included: overflow drops, separators still tried
      for (int s = 0; s <= 4; s++) begin
         write_out_size(16'(s));
         queue_short_query();
         wait_until_drained();
      end

      // Random phases; some continue the previous query under a new size
      repeat (3) begin
         case ($urandom_range(0, 4))
            0: next_size = 16'($urandom_range(1, 12));
            1: next_size = 16'($urandom_range(13, 60));
            2: next_size = fqse_pkg::OUT_SIZE_RESET;
            3: next_size = 16'hFFFF;
            default: next_size = 16'($urandom_range(0, 65535));
         endcase
         write_out_size(next_size);
         queue_random_items(12);
         wait_until_drained();
      end

      // Largest buffer: a short query far below the limit
      write_out_size(16'hFFFF);
      queue_item(fqse_pkg::MODE_START_QUERY, 8'h00);
      queue_item(fqse_pkg::MODE_NAME_BYTE, "a");
      queue_item(fqse_pkg::MODE_SEPARATOR, 8'h00);
      queue_item(fqse_pkg::MODE_VALUE_BYTE, 8'hC3);
      queue_item(fqse_pkg::MODE_START_PAIR, 8'h00);
      wait_until_drained();

      $display("Run covered %0d items and %0d encoded bytes under %0d buffer sizes",
               items_taken, beats_checked, size_writes);
      $display("%0d fields were cut short at the buffer limit, %0d failures",
               drops, failures);
      if (failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// File: sim.f
design/fqse_pkg.sv
design/fqse_front.sv
design/fqse_fifo.sv
design/fqse_back.sv
design/form_query_string_encoder_top.sv
dv/tb_top.sv
